FILE: rtl/core/mtap_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and control word layout for the all-pairs path engine.
package mtap_pkg;

    localparam int MAX_CITIES_DEF = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam int INDEX_W    = 6;
    localparam int CNT_W      = 7;
    localparam int COST_W     = 12;
    localparam int DIST_W     = 13;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIST_W-1:0] DIST_MAX       = 13'h1FFF;
    localparam logic [CNT_W-1:0]  CITY_COUNT_RST = 7'd64;
    localparam logic [COST_W-1:0] TELEPORT_RST   = 12'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TELEPORT_COST = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_QUERY   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        DSEL_IK,
        DSEL_KJ,
        DSEL_QUERY
    } t_dsel;

    typedef enum logic [2:0] {
        DOP_NONE,
        DOP_ACCEPT,
        DOP_EDGE_DIFF,
        DOP_EDGE_WRITE,
        DOP_LATCH_DIK,
        DOP_RELAX,
        DOP_QUERY_OUT
    } t_dop;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_STEP_IJ,
        CNT_STEP_KIJ
    } t_cnt;

    typedef struct packed {
        t_dsel dsel;
        t_dop  op;
        t_cnt  cnt;
    } t_dctl;

    typedef struct packed {
        logic j_last;
        logic ij_last;
        logic ik_zero;
        logic out_free;
        logic n_zero;
    } t_dstat;

endpackage

FILE: rtl/core/mtap_sequencer.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store and jump logic.
module mtap_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_action,
    input  mtap_pkg::t_dstat   i_stat,
    output logic               o_busy,
    output mtap_pkg::t_dctl    o_ctl
);

    localparam int STEP_W = 4;

    typedef enum logic [STEP_W-1:0] {
        ST_IDLE,
        ST_EI_RD,
        ST_EI_DIFF,
        ST_EI_WR,
        ST_FW_RD_IK,
        ST_FW_LATCH,
        ST_FW_RD,
        ST_FW_RELAX,
        ST_FW_ROW,
        ST_FW_DONE,
        ST_Q_RD,
        ST_Q_OUT
    } t_step;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NOT_IJ_LAST,
        COND_NOT_J_LAST,
        COND_NOT_IK_ZERO,
        COND_OUT_FREE,
        COND_DISPATCH
    } t_cond;

    typedef struct packed {
        t_cond           cond;
        logic            stay;
        t_step           target;
        mtap_pkg::t_dctl dctl;
    } t_uword;

    t_step  r_pc;
    t_step  n_pc;
    t_uword w;
    t_step  dispatch_pc;
    logic   jump;

    always_comb begin
        w = '{cond: COND_NEXT, stay: 1'b0, target: ST_IDLE,
              dctl: '{dsel: mtap_pkg::DSEL_IK, op: mtap_pkg::DOP_NONE,
                      cnt: mtap_pkg::CNT_HOLD}};
        unique case (r_pc)
            ST_IDLE: begin
                w.cond     = COND_DISPATCH;
                w.dctl.op  = mtap_pkg::DOP_ACCEPT;
                w.dctl.cnt = mtap_pkg::CNT_CLEAR;
            end
            ST_EI_RD: begin
                w.cond = COND_NEXT;
            end
            ST_EI_DIFF: begin
                w.dctl.op = mtap_pkg::DOP_EDGE_DIFF;
            end
            ST_EI_WR: begin
                w.cond     = COND_NOT_IJ_LAST;
                w.target   = ST_EI_RD;
                w.dctl.op  = mtap_pkg::DOP_EDGE_WRITE;
                w.dctl.cnt = mtap_pkg::CNT_STEP_IJ;
            end
            ST_FW_RD_IK: begin
                w.dctl.dsel = mtap_pkg::DSEL_IK;
            end
            ST_FW_LATCH: begin
                w.dctl.op = mtap_pkg::DOP_LATCH_DIK;
            end
            ST_FW_RD: begin
                w.dctl.dsel = mtap_pkg::DSEL_KJ;
            end
            ST_FW_RELAX: begin
                w.cond     = COND_NOT_J_LAST;
                w.target   = ST_FW_RD;
                w.dctl.op  = mtap_pkg::DOP_RELAX;
                w.dctl.cnt = mtap_pkg::CNT_STEP_KIJ;
            end
            ST_FW_ROW: begin
                w.cond   = COND_NOT_IK_ZERO;
                w.target = ST_FW_RD_IK;
            end
            ST_FW_DONE: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            ST_Q_RD: begin
                w.dctl.dsel = mtap_pkg::DSEL_QUERY;
            end
            ST_Q_OUT: begin
                w.cond      = COND_OUT_FREE;
                w.stay      = 1'b1;
                w.target    = ST_IDLE;
                w.dctl.dsel = mtap_pkg::DSEL_QUERY;
                w.dctl.op   = mtap_pkg::DOP_QUERY_OUT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (!i_accept) begin
            dispatch_pc = ST_IDLE;
        end else if (mtap_pkg::t_action'(i_action) == mtap_pkg::ACT_COMPUTE
                     && !i_stat.n_zero) begin
            dispatch_pc = ST_EI_RD;
        end else if (mtap_pkg::t_action'(i_action) == mtap_pkg::ACT_QUERY) begin
            dispatch_pc = ST_Q_RD;
        end else begin
            dispatch_pc = ST_IDLE;
        end
    end

    always_comb begin
        unique case (w.cond)
            COND_NEXT:        jump = 1'b0;
            COND_ALWAYS:      jump = 1'b1;
            COND_NOT_IJ_LAST: jump = !i_stat.ij_last;
            COND_NOT_J_LAST:  jump = !i_stat.j_last;
            COND_NOT_IK_ZERO: jump = !i_stat.ik_zero;
            COND_OUT_FREE:    jump = i_stat.out_free;
            default:          jump = 1'b0;
        endcase
    end

    always_comb begin
        priority if (w.cond == COND_DISPATCH) begin
            n_pc = dispatch_pc;
        end else if (jump) begin
            n_pc = w.target;
        end else if (w.stay) begin
            n_pc = r_pc;
        end else begin
            n_pc = t_step'(STEP_W'(r_pc) + STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_busy = (r_pc != ST_IDLE);
    assign o_ctl  = w.dctl;

endmodule

FILE: rtl/core/mtap_datapath.sv
`timescale 1ns / 1ps
// Datapath: city and distance memories, loop counters, edge and relaxation arithmetic.
module mtap_datapath #(
    parameter int MAX_CITIES = mtap_pkg::MAX_CITIES_DEF,
    parameter int COORD_BITS = mtap_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mtap_pkg::t_dctl                     i_ctl,
    output mtap_pkg::t_dstat                    o_stat,
    input  logic                                i_accept,
    input  logic [1:0]                          i_action,
    input  logic [mtap_pkg::INDEX_W-1:0]        i_source_index,
    input  logic [mtap_pkg::INDEX_W-1:0]        i_dest_index,
    input  logic signed [COORD_BITS-1:0]        i_coord_x,
    input  logic signed [COORD_BITS-1:0]        i_coord_y,
    input  logic                                i_is_special,
    input  logic [mtap_pkg::CNT_W-1:0]          i_n_active,
    input  logic [mtap_pkg::COST_W-1:0]         i_teleport_cost,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [mtap_pkg::DIST_W-1:0]         o_distance,
    output logic                                o_bad_index
);

    localparam int IDX_W  = $clog2(MAX_CITIES);
    localparam int AW     = 2 * IDX_W;
    localparam int DEPTH  = 1 << AW;
    localparam int LW     = (IDX_W + 1 > mtap_pkg::CNT_W) ? IDX_W + 1 : mtap_pkg::CNT_W;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SUM_W  = DIFF_W + 1;
    localparam int REC_W  = 2 * COORD_BITS + 1;
    localparam int DW     = mtap_pkg::DIST_W;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                   input logic signed [COORD_BITS-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic [REC_W-1:0] r_coord_mem [MAX_CITIES];
    logic [DW-1:0]    r_dist_mem  [DEPTH];

    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic [IDX_W-1:0] n_i, n_j, n_k;
    logic [REC_W-1:0] r_ca, r_cb;
    logic [DIFF_W-1:0] r_dx, r_dy;
    logic             r_both_sp;
    logic [DW-1:0]    r_da, r_db, r_dik;
    logic [AW-1:0]    r_q_addr;
    logic             r_q_bad;
    logic             r_o_valid;
    logic [DW-1:0]    r_o_distance;
    logic             r_o_bad;

    logic             i_last, j_last, k_last;
    logic             load_we;
    logic [IDX_W-1:0] load_idx;
    logic             q_bad;
    logic [AW-1:0]    addr_a, addr_ij;
    logic [SUM_W-1:0] edge_sum;
    logic [DW-1:0]    edge_sat, edge_d;
    logic [DW:0]      via;
    logic [DW-1:0]    via_sat;
    logic             dist_we;
    logic [DW-1:0]    dist_wdata;
    logic             out_free;
    logic             out_load;

    assign i_last = (LW'(r_i) + LW'(1)) == LW'(i_n_active);
    assign j_last = (LW'(r_j) + LW'(1)) == LW'(i_n_active);
    assign k_last = (LW'(r_k) + LW'(1)) == LW'(i_n_active);

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        unique case (i_ctl.cnt)
            mtap_pkg::CNT_HOLD: begin
            end
            mtap_pkg::CNT_CLEAR: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
            end
            mtap_pkg::CNT_STEP_IJ: begin
                n_j = j_last ? '0 : r_j + IDX_W'(1);
                if (j_last) begin
                    n_i = i_last ? '0 : r_i + IDX_W'(1);
                end
            end
            mtap_pkg::CNT_STEP_KIJ: begin
                n_j = j_last ? '0 : r_j + IDX_W'(1);
                if (j_last) begin
                    n_i = i_last ? '0 : r_i + IDX_W'(1);
                    if (i_last) begin
                        n_k = k_last ? '0 : r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
        end
    end

    assign load_idx = IDX_W'(i_source_index);
    assign load_we  = i_accept && (i_ctl.op == mtap_pkg::DOP_ACCEPT)
                      && (mtap_pkg::t_action'(i_action) == mtap_pkg::ACT_LOAD)
                      && (32'(i_source_index) < MAX_CITIES);

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_coord_mem[load_idx] <= {i_is_special, i_coord_y, i_coord_x};
        end
        r_ca <= r_coord_mem[r_i];
        r_cb <= r_coord_mem[r_j];
    end

    assign q_bad = (mtap_pkg::CNT_W'(i_source_index) >= i_n_active)
                   || (mtap_pkg::CNT_W'(i_dest_index) >= i_n_active);

    always_ff @(posedge i_clk) begin
        if (i_accept && i_ctl.op == mtap_pkg::DOP_ACCEPT) begin
            r_q_addr <= {IDX_W'(i_source_index), IDX_W'(i_dest_index)};
            r_q_bad  <= q_bad;
        end
        if (i_ctl.op == mtap_pkg::DOP_EDGE_DIFF) begin
            r_dx      <= abs_diff(r_ca[COORD_BITS-1:0], r_cb[COORD_BITS-1:0]);
            r_dy      <= abs_diff(r_ca[2*COORD_BITS-1:COORD_BITS],
                                  r_cb[2*COORD_BITS-1:COORD_BITS]);
            r_both_sp <= r_ca[REC_W-1] && r_cb[REC_W-1];
        end
        if (i_ctl.op == mtap_pkg::DOP_LATCH_DIK) begin
            r_dik <= r_da;
        end
    end

    assign edge_sum = SUM_W'(r_dx) + SUM_W'(r_dy);
    assign edge_sat = (32'(edge_sum) > 32'(mtap_pkg::DIST_MAX)) ? mtap_pkg::DIST_MAX
                                                              : DW'(edge_sum);
    assign edge_d   = (r_both_sp && (DW'(i_teleport_cost) < edge_sat)) ? DW'(i_teleport_cost)
                                                                      : edge_sat;

    assign via     = (DW + 1)'(r_dik) + (DW + 1)'(r_da);
    assign via_sat = via[DW] ? mtap_pkg::DIST_MAX : via[DW-1:0];

    always_comb begin
        unique case (i_ctl.dsel)
            mtap_pkg::DSEL_IK:    addr_a = {r_i, r_k};
            mtap_pkg::DSEL_KJ:    addr_a = {r_k, r_j};
            mtap_pkg::DSEL_QUERY: addr_a = r_q_addr;
            default:              addr_a = r_q_addr;
        endcase
    end

    assign addr_ij    = {r_i, r_j};
    assign dist_we    = (i_ctl.op == mtap_pkg::DOP_EDGE_WRITE)
                        || ((i_ctl.op == mtap_pkg::DOP_RELAX) && (via_sat < r_db));
    assign dist_wdata = (i_ctl.op == mtap_pkg::DOP_EDGE_WRITE) ? edge_d : via_sat;

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[addr_ij] <= dist_wdata;
        end
        r_da <= r_dist_mem[addr_a];
        r_db <= r_dist_mem[addr_ij];
    end

    assign out_free = !r_o_valid || !i_out_stall;
    assign out_load = (i_ctl.op == mtap_pkg::DOP_QUERY_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_distance <= r_q_bad ? '0 : r_da;
            r_o_bad      <= r_q_bad;
        end
    end

    assign o_stat = '{j_last:   j_last,
                      ij_last:  i_last && j_last,
                      ik_zero:  (r_i == '0) && (r_k == '0),
                      out_free: out_free,
                      n_zero:   (i_n_active == '0)};

    assign o_out_valid = r_o_valid;
    assign o_distance  = r_o_distance;
    assign o_bad_index = r_o_bad;

endmodule

FILE: rtl/core/manhattan_teleport_all_pairs_paths.sv
`timescale 1ns / 1ps
// Top level: configuration registers, microcode sequencer and datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | action, indices, coords, is_special
//  out     | output    | o_out_valid / i_out_stall| distance, bad_index
//  cfg     | input     | i_cfg_wr_en              | i_cfg_index, i_cfg_wdata
//
// Load: done from the idle step; input stays ready. Query: read step, then an output step
// that waits on i_out_stall. Compute, set by the single-port-write distance memory: read,
// diff, write steps per edge; read, relax per relaxation; read, latch, row per (k, i) row.
// o_in_stall is high while the sequencer is off its idle step.
// Reset is synchronous; memories are not cleared, so query only after a compute.
module manhattan_teleport_all_pairs_paths #(
    parameter int MAX_CITIES = mtap_pkg::MAX_CITIES_DEF,
    parameter int COORD_BITS = mtap_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_action,
    input  logic [mtap_pkg::INDEX_W-1:0]         i_source_index,
    input  logic [mtap_pkg::INDEX_W-1:0]         i_dest_index,
    input  logic signed [COORD_BITS-1:0]         i_coord_x,
    input  logic signed [COORD_BITS-1:0]         i_coord_y,
    input  logic                                 i_is_special,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [mtap_pkg::DIST_W-1:0]          o_distance,
    output logic                                 o_bad_index,
    input  logic                                 i_cfg_wr_en,
    input  logic [mtap_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mtap_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    logic [mtap_pkg::CNT_W-1:0]  r_city_count;
    logic [mtap_pkg::COST_W-1:0] r_teleport_cost;
    logic [mtap_pkg::CNT_W-1:0]  n_active;
    logic                        busy;
    logic                        accept;
    mtap_pkg::t_dctl             ctl;
    mtap_pkg::t_dstat            stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count    <= mtap_pkg::CITY_COUNT_RST;
            r_teleport_cost <= mtap_pkg::TELEPORT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mtap_pkg::CFG_CITY_COUNT:    r_city_count    <= i_cfg_wdata[mtap_pkg::CNT_W-1:0];
                mtap_pkg::CFG_TELEPORT_COST: r_teleport_cost <= i_cfg_wdata[mtap_pkg::COST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign n_active = (32'(r_city_count) > MAX_CITIES) ? mtap_pkg::CNT_W'(MAX_CITIES)
                                                       : r_city_count;

    assign accept     = i_in_valid && !busy;
    assign o_in_stall = busy;

    mtap_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_action),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_ctl    (ctl)
    );

    mtap_datapath #(
        .MAX_CITIES (MAX_CITIES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_accept        (accept),
        .i_action        (i_action),
        .i_source_index  (i_source_index),
        .i_dest_index    (i_dest_index),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_is_special    (i_is_special),
        .i_n_active      (n_active),
        .i_teleport_cost (r_teleport_cost),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_distance      (o_distance),
        .o_bad_index     (o_bad_index)
    );

endmodule

FILE: rtl/core/mtap_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the all-pairs path engine, bound to the top level.
module mtap_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_stall,
    input logic [1:0]                    i_action,
    input logic                          i_out_valid,
    input logic                          i_out_stall,
    input logic [mtap_pkg::DIST_W-1:0]   i_distance,
    input logic                          i_bad_index
);

    logic in_xfer;

    assign in_xfer = i_in_valid && !i_in_stall;

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_action == mtap_pkg::ACT_QUERY) |=> i_in_stall)
        else $error("query transfer did not make the input side busy");

    a_load_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_action == mtap_pkg::ACT_LOAD) |=> !i_in_stall)
        else $error("load transfer made the input side busy");

    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_index |-> (i_distance == '0))
        else $error("bad index result with nonzero distance");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_distance)
                                       && $stable(i_bad_index))
        else $error("stalled result changed or dropped");

endmodule

bind manhattan_teleport_all_pairs_paths mtap_checker u_mtap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_action    (i_action),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_distance  (o_distance),
    .i_bad_index (o_bad_index)
);

FILE: bench/travel_time_checker.sv
`timescale 1ns / 1ps
// Checker for the all-pairs path engine: predicts every query result and compares it.
module travel_time_checker
    import mtap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_action,
    input  logic [INDEX_W-1:0]    i_source_index,
    input  logic [INDEX_W-1:0]    i_dest_index,
    input  logic [COORD_BITS_DEF-1:0] i_coord_x,
    input  logic [COORD_BITS_DEF-1:0] i_coord_y,
    input  logic                  i_is_special,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [DIST_W-1:0]     i_distance,
    input  logic                  i_bad_index,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatch_count,
    output int                    o_trips_pending
);

    localparam int N_MAX = MAX_CITIES_DEF;
    localparam int CW    = COORD_BITS_DEF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              bad_index;
    } t_trip;

    logic signed [CW-1:0] city_x [N_MAX];
    logic signed [CW-1:0] city_y [N_MAX];
    logic                 city_special [N_MAX];
    logic [DIST_W-1:0]    travel [N_MAX][N_MAX];
    logic [CNT_W-1:0]     city_count;
    logic [COST_W-1:0]    teleport_cost;
    t_trip                expected_trips [$];

    function automatic int active_cities();
        return (city_count > N_MAX) ? N_MAX : int'(city_count);
    endfunction

    function automatic void relax_all_pairs();
        int n, dx, dy, span, via;
        n = active_cities();
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                dx = int'(city_x[i]) - int'(city_x[j]);
                dy = int'(city_y[i]) - int'(city_y[j]);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                span = dx + dy;
                if (span > int'(DIST_MAX)) span = int'(DIST_MAX);
                if (city_special[i] && city_special[j] && int'(teleport_cost) < span) begin
                    span = int'(teleport_cost);
                end
                travel[i][j] = span[DIST_W-1:0];
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    via = int'(travel[i][k]) + int'(travel[k][j]);
                    if (via > int'(DIST_MAX)) via = int'(DIST_MAX);
                    if (via < int'(travel[i][j])) travel[i][j] = via[DIST_W-1:0];
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_trip want;
        if (!i_rst_n) begin
            city_count = CITY_COUNT_RST;
            teleport_cost = TELEPORT_RST;
            expected_trips.delete();
            o_mismatch_count = 0;
            o_trips_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_trips.size() == 0) begin
                    $error("unexpected result: distance %0d bad_index %0b",
                           i_distance, i_bad_index);
                    o_mismatch_count++;
                end else begin
                    want = expected_trips.pop_front();
                    if (i_distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d", want.distance, i_distance);
                        o_mismatch_count++;
                    end
                    if (i_bad_index !== want.bad_index) begin
                        $error("bad_index: expected %0b, actual %0b",
                               want.bad_index, i_bad_index);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CITY_COUNT:    city_count = i_cfg_wdata[CNT_W-1:0];
                    CFG_TELEPORT_COST: teleport_cost = i_cfg_wdata[COST_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_action)
                    ACT_LOAD: begin
                        city_x[i_source_index] = i_coord_x;
                        city_y[i_source_index] = i_coord_y;
                        city_special[i_source_index] = i_is_special;
                    end
                    ACT_COMPUTE: relax_all_pairs();
                    ACT_QUERY: begin
                        want.bad_index = (i_source_index >= active_cities()) ||
                                         (i_dest_index >= active_cities());
                        want.distance = want.bad_index ? '0 :
                                        travel[i_source_index][i_dest_index];
                        expected_trips.push_back(want);
                    end
                    default: ;
                endcase
            end
            o_trips_pending <= expected_trips.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Bench top: clock, reset, stimulus and verdict for the all-pairs path engine.
module testbench;
    import mtap_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int N_MAX = MAX_CITIES_DEF;
    localparam int CW    = COORD_BITS_DEF;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            action;
    logic [INDEX_W-1:0]    source_index;
    logic [INDEX_W-1:0]    dest_index;
    logic signed [CW-1:0]  coord_x;
    logic signed [CW-1:0]  coord_y;
    logic                  is_special;
    logic                  out_valid;
    logic                  out_stall;
    logic [DIST_W-1:0]     distance;
    logic                  bad_index;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int transfers_sent = 0;
    int ready_n = 0;
    int active_n = N_MAX;
    int mismatch_count;
    int trips_pending;

    manhattan_teleport_all_pairs_paths dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action),
        .i_source_index (source_index),
        .i_dest_index   (dest_index),
        .i_coord_x      (coord_x),
        .i_coord_y      (coord_y),
        .i_is_special   (is_special),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_distance     (distance),
        .o_bad_index    (bad_index),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    travel_time_checker trip_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_action         (action),
        .i_source_index   (source_index),
        .i_dest_index     (dest_index),
        .i_coord_x        (coord_x),
        .i_coord_y        (coord_y),
        .i_is_special     (is_special),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_distance       (distance),
        .i_bad_index      (bad_index),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .o_mismatch_count (mismatch_count),
        .o_trips_pending  (trips_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_coord(input bit wide);
        if (wide) return int'($urandom_range(4095)) - 2048;
        return int'($urandom_range(64)) - 32;
    endfunction

    task automatic send_item(input logic [1:0] act, input int src, input int dst,
                             input int x, input int y, input bit sp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        source_index <= src[INDEX_W-1:0];
        dest_index   <= dst[INDEX_W-1:0];
        coord_x      <= x[CW-1:0];
        coord_y      <= y[CW-1:0];
        is_special   <= sp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (act != ACT_UNUSED) transfers_sent++;
    endtask

    task automatic load_city(input int idx, input int x, input int y, input bit sp);
        send_item(ACT_LOAD, idx, $urandom_range(63), x, y, sp);
    endtask

    task automatic run_compute();
        send_item(ACT_COMPUTE, $urandom_range(63), $urandom_range(63),
                  pick_coord(1), pick_coord(1), $urandom_range(1));
        if (active_n > ready_n) ready_n = active_n;
    endtask

    task automatic ask(input int src, input int dst);
        send_item(ACT_QUERY, src, dst, pick_coord(1), pick_coord(1), $urandom_range(1));
    endtask

    task automatic send_noise();
        send_item(ACT_UNUSED, $urandom_range(63), $urandom_range(63),
                  pick_coord(1), pick_coord(1), $urandom_range(1));
    endtask

    task automatic random_query();
        int vn, src, dst;
        vn = (active_n < ready_n) ? active_n : ready_n;
        if (active_n < N_MAX && (vn == 0 || $urandom_range(99) < 20)) begin
            src = $urandom_range(63);
            dst = $urandom_range(63);
            if (src < active_n && dst < active_n) begin
                if ($urandom_range(1)) src = $urandom_range(N_MAX - 1, active_n);
                else dst = $urandom_range(N_MAX - 1, active_n);
            end
            ask(src, dst);
        end else if (vn > 0) begin
            ask($urandom_range(vn - 1), $urandom_range(vn - 1));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // hold off until every query result is out and the sequencer is back at idle
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (trips_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(input int count, input int cost);
        quiesce();
        write_reg(CFG_CITY_COUNT, count);
        write_reg(CFG_TELEPORT_COST, cost);
        active_n = (count > N_MAX) ? N_MAX : count;
    endtask

    task automatic run_round(input int count, input int cost, input bit fresh, input int extra);
        int order [N_MAX];
        int j, tmp, r;
        bit wide;
        set_regs(count, cost);
        wide = $urandom_range(1);
        if (fresh) begin
            for (int i = 0; i < active_n; i++) order[i] = i;
            for (int i = active_n - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < active_n; i++) begin
                if ($urandom_range(99) < 8) send_noise();
                load_city(order[i], pick_coord(wide), pick_coord(wide), $urandom_range(1));
            end
            run_compute();
        end
        repeat (extra) begin
            r = $urandom_range(99);
            if (r < 65) begin
                random_query();
            end else if (r < 85) begin
                load_city($urandom_range(63), pick_coord(wide), pick_coord(wide),
                          $urandom_range(1));
            end else if (r < 92 && active_n <= 16) begin
                run_compute();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int hold_pct, input int target);
        int r, count, cost;
        quiesce();
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        transfers_sent = 0;
        while (transfers_sent < target) begin
            r = $urandom_range(99);
            if (r < 4) count = 0;
            else if (r < 12) count = 1;
            else if (r < 85) count = $urandom_range(8, 2);
            else count = $urandom_range(16, 9);
            case ($urandom_range(3))
                0: cost = 0;
                1: cost = 4095;
                2: cost = $urandom_range(100);
                default: cost = $urandom_range(4095);
            endcase
            run_round(count, cost, 1'b1, $urandom_range(40, 15));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_LOAD;
        source_index = '0;
        dest_index = '0;
        coord_x = '0;
        coord_y = '0;
        is_special = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_CITY_COUNT;
        cfg_wdata = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_regs(4, 0);
        load_city(0, -2048, -2048, 1'b1);
        send_item(ACT_LOAD, 1, 63, 2047, 2047, 1'b1);
        load_city(2, -2048, 2047, 1'b0);
        load_city(3, 2047, -2048, 1'b1);
        load_city(63, 0, 0, 1'b0);
        send_item(ACT_UNUSED, 63, 63, -1, -1, 1'b1);
        run_compute();
        ask(0, 1);
        ask(0, 2);
        ask(1, 2);
        ask(3, 3);
        ask(4, 0);
        ask(0, 63);
        ask(63, 63);
        set_regs(0, 4095);
        run_compute();
        ask(0, 0);
        set_regs(1, 4095);
        run_compute();
        ask(0, 0);
        ask(0, 1);
        set_regs(4, 4095);
        ask(1, 2);
        load_city(1, 100, -100, 1'b1);
        run_compute();
        ask(0, 1);
        ask(3, 1);

        // full-size pass: count above the city limit, then the limit itself
        quiesce();
        transfers_sent = 0;
        run_round(127, $urandom_range(4095), 1'b1, 40);
        run_round(64, 4095, 1'b0, 30);
        run_phase(0, 0, 120);
        run_phase(84, 0, 240);
        run_phase(0, 84, 240);
        run_phase(9, 9, 240);

        quiesce();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && trips_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
